FILE: sv/two_level_page_table_walker_macros.svh
// Assertion macros for the page table walker.
`ifndef TWO_LEVEL_PAGE_TABLE_WALKER_MACROS_SVH
`define TWO_LEVEL_PAGE_TABLE_WALKER_MACROS_SVH

`ifndef SYNTHESIS

`define TLPW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define TLPW_ASSERT_NEVER(lbl, cond, msg) \
  `TLPW_ASSERT(lbl, !(cond), msg)

`else

`define TLPW_ASSERT(lbl, prop, msg)

`define TLPW_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

FILE: sv/tlpw_pkg.sv
package tlpw_pkg;

  localparam logic       OpTranslate = 1'b0;
  localparam logic       OpResponse  = 1'b1;

  localparam logic [1:0] KindRead  = 2'd0;
  localparam logic [1:0] KindWrite = 2'd1;
  localparam logic [1:0] KindDone  = 2'd2;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgDirBase  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgAddrMask = 1'd1;

  localparam logic [31:0] DummyAddr = 32'h0100_0000;
  localparam logic [7:0]  BitAccessed = 8'h20;
  localparam logic [7:0]  BitDirty    = 8'h40;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [7:0]  write_byte;
    logic        fault;
  } res_t;

  typedef struct packed {
    logic has_wb;
    res_t wb;
    res_t fin;
  } job_t;

endpackage

FILE: sv/tlpw_front.sv
module tlpw_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tlpw_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  input  logic                         accept_i,
  input  logic                         operation_i,
  input  logic [31:0]                  linear_address_i,
  input  logic                         is_write_i,
  input  logic [31:0]                  read_data_i,
  output logic                         push_o,
  output tlpw_pkg::job_t               job_o
);

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhDir  = 2'd1;
  localparam logic [1:0] PhTbl  = 2'd2;

  logic [31:0] dir_base_q, addr_mask_q;
  logic [1:0]  phase_q, phase_d;
  logic [31:0] held_lin_q, held_lin_d;
  logic        held_wr_q, held_wr_d;
  logic [31:0] te_addr_q, te_addr_d;
  logic        emit;
  logic [31:0] lin;
  logic [31:0] dir_addr;
  logic [31:0] te_sum;
  logic [7:0]  set_bits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_base_q  <= '0;
      addr_mask_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tlpw_pkg::CfgDirBase:  dir_base_q  <= cfg_data_i;
        tlpw_pkg::CfgAddrMask: addr_mask_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign lin      = (operation_i == tlpw_pkg::OpTranslate) ? linear_address_i : held_lin_q;
  assign dir_addr = (dir_base_q + {20'd0, lin[31:22], 2'b00}) & addr_mask_q;
  assign te_sum   = {read_data_i[31:12], 12'd0} + {20'd0, held_lin_q[21:12], 2'b00};

  always_comb begin
    phase_d    = phase_q;
    held_lin_d = held_lin_q;
    held_wr_d  = held_wr_q;
    te_addr_d  = te_addr_q;
    emit       = 1'b0;
    set_bits   = '0;
    job_o      = '0;
    if (operation_i == tlpw_pkg::OpTranslate) begin
      held_lin_d            = linear_address_i;
      held_wr_d             = is_write_i;
      phase_d               = PhDir;
      emit                  = 1'b1;
      job_o.fin.kind        = tlpw_pkg::KindRead;
      job_o.fin.address     = dir_addr;
    end else begin
      unique case (phase_q)
        PhDir: begin
          emit = 1'b1;
          if (!read_data_i[0]) begin
            phase_d           = PhIdle;
            job_o.fin.kind    = tlpw_pkg::KindDone;
            job_o.fin.address = tlpw_pkg::DummyAddr & addr_mask_q;
            job_o.fin.fault   = 1'b1;
          end else begin
            phase_d             = PhTbl;
            te_addr_d           = te_sum;
            job_o.has_wb        = !read_data_i[5];
            job_o.wb.kind       = tlpw_pkg::KindWrite;
            job_o.wb.address    = dir_addr;
            job_o.wb.write_byte = read_data_i[7:0] | tlpw_pkg::BitAccessed;
            job_o.fin.kind      = tlpw_pkg::KindRead;
            job_o.fin.address   = te_sum & addr_mask_q;
          end
        end
        PhTbl: begin
          emit    = 1'b1;
          phase_d = PhIdle;
          if (!read_data_i[0]) begin
            job_o.fin.kind    = tlpw_pkg::KindDone;
            job_o.fin.address = tlpw_pkg::DummyAddr & addr_mask_q;
            job_o.fin.fault   = 1'b1;
          end else begin
            if (!read_data_i[5]) set_bits = set_bits | tlpw_pkg::BitAccessed;
            if (held_wr_q && !read_data_i[6]) set_bits = set_bits | tlpw_pkg::BitDirty;
            job_o.has_wb        = (set_bits != 8'd0);
            job_o.wb.kind       = tlpw_pkg::KindWrite;
            job_o.wb.address    = te_addr_q & addr_mask_q;
            job_o.wb.write_byte = read_data_i[7:0] | set_bits;
            job_o.fin.kind      = tlpw_pkg::KindDone;
            job_o.fin.address   = {read_data_i[31:12], held_lin_q[11:0]} & addr_mask_q;
          end
        end
        default: ;
      endcase
    end
  end

  assign push_o = accept_i && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      held_lin_q <= '0;
      held_wr_q  <= 1'b0;
      te_addr_q  <= '0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      held_lin_q <= held_lin_d;
      held_wr_q  <= held_wr_d;
      te_addr_q  <= te_addr_d;
    end
  end

endmodule

FILE: sv/tlpw_queue.sv
module tlpw_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tlpw_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tlpw_pkg::job_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tlpw_pkg::job_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: sv/tlpw_back.sv
module tlpw_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  tlpw_pkg::job_t job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tlpw_pkg::res_t res_o,
  output logic           last_o
);

  logic           valid_q;
  tlpw_pkg::res_t res_q;
  logic           last_q;
  logic           pend_valid_q;
  tlpw_pkg::res_t pend_q;
  logic           load;

  assign load  = !valid_q || !out_stall_i;
  assign pop_o = load && !pend_valid_q && job_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      pend_valid_q <= 1'b0;
    end else if (load) begin
      priority if (pend_valid_q) begin
        valid_q      <= 1'b1;
        pend_valid_q <= 1'b0;
      end else if (job_valid_i) begin
        valid_q      <= 1'b1;
        pend_valid_q <= job_i.has_wb;
      end else begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      priority if (pend_valid_q) begin
        res_q  <= pend_q;
        last_q <= 1'b1;
      end else if (job_valid_i && job_i.has_wb) begin
        res_q  <= job_i.wb;
        last_q <= 1'b0;
        pend_q <= job_i.fin;
      end else begin
        res_q  <= job_i.fin;
        last_q <= 1'b1;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;
  assign last_o      = last_q;

endmodule

FILE: sv/two_level_page_table_walker.sv
// Two-level page table walker for 32-bit linear addresses and 4 KiB pages. The input
// channel carries translate requests and memory read responses; each accepted item
// yields zero, one or two result items on the output channel: dword read requests,
// byte write-backs of entries whose accessed or dirty bit must be set, and the final
// translated address (or the masked dummy address with fault on a non-present entry).
// The input takes one item per cycle unless stalled; an item's first result passes
// the queue, then the output register. Results leave one per cycle unless stalled; a
// write-back precedes its final result. Up to QueueDepth classified items wait
// between the two sides; the input stalls only when that queue is full. The user must
// write configuration only while no walk step is in flight; it is not enforced.
`include "two_level_page_table_walker_macros.svh"

module two_level_page_table_walker #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tlpw_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         operation_i,
  input  logic [31:0]                  linear_address_i,
  input  logic                         is_write_i,
  input  logic [31:0]                  read_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   kind_o,
  output logic [31:0]                  address_o,
  output logic [7:0]                   write_byte_o,
  output logic                         fault_o,
  output logic                         last_o
);

  logic           q_full, q_valid, push, pop, accept;
  tlpw_pkg::job_t push_job, pop_job;
  tlpw_pkg::res_t res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign accept      = in_valid_i && !q_full;

  tlpw_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .accept_i         (accept),
    .operation_i      (operation_i),
    .linear_address_i (linear_address_i),
    .is_write_i       (is_write_i),
    .read_data_i      (read_data_i),
    .push_o           (push),
    .job_o            (push_job)
  );

  tlpw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_job)
  );

  tlpw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res),
    .last_o      (last_o)
  );

  assign kind_o       = res.kind;
  assign address_o    = res.address;
  assign write_byte_o = res.write_byte;
  assign fault_o      = res.fault;

  `TLPW_ASSERT_NEVER(a_wb_not_last, out_valid_o && kind_o == tlpw_pkg::KindWrite && last_o, "write-back marked last")
  `TLPW_ASSERT(a_fault_done, out_valid_o && fault_o |-> kind_o == tlpw_pkg::KindDone && last_o, "fault on non-final item")
  `TLPW_ASSERT(a_wb_then_next, out_valid_o && !out_stall_i && kind_o == tlpw_pkg::KindWrite |=> out_valid_o && last_o, "write-back not followed")
  `TLPW_ASSERT_NEVER(a_byte_only_wb, out_valid_o && kind_o != tlpw_pkg::KindWrite && write_byte_o != 8'd0, "stray write byte")

endmodule
